// ===== sv/quadrant_atan2_approximation_assert.svh =====
// Assertion macros shared by the quadrant arctangent RTL.
`ifndef QUADRANT_ATAN2_APPROXIMATION_ASSERT_SVH
`define QUADRANT_ATAN2_APPROXIMATION_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge, suspended while reset is high.
`define QA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("assertion failed");
// Checked on every rising edge, also during reset.
`define QA_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("reset assertion failed");
`else
`define QA_ASSERT(lbl, prop)
`define QA_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/qa_pkg.sv =====
// Shared types and constants of the quadrant arctangent block.
`default_nettype none
package qa_pkg;
  localparam int ANGLE_W                 = 14;
  localparam int FRAC_STEPS              = 15;
  localparam int RATIO_W                 = 15;
  localparam int PROD_W                  = 27;
  localparam int CORR_PRE_SHIFT          = 10;
  localparam int SCALED_W                = 17;
  localparam int RECIP                   = 93207;
  localparam int RECIP_SHIFT             = 22;
  localparam int RECIP_PROD_W            = 34;
  localparam int FULL_TURN               = 16384;
  localparam int THREE_QUARTER_TURN      = 12288;
  localparam int HALF_TURN               = 8192;
  localparam int QUARTER_TURN            = 4096;
  localparam int DEFAULT_COMPONENT_WIDTH = 32;
  localparam int DEFAULT_QUEUE_DEPTH     = 4;

  typedef struct packed {
    logic               yneg;
    logic               xneg;
    logic               ylt;
    logic               eq;
    logic               special;
    logic [ANGLE_W-1:0] spec_angle;
  } qa_flags_t;

  localparam int FLAGS_W = $bits(qa_flags_t);
endpackage
`default_nettype wire

// ===== sv/qa_front.sv =====
// Front end: component magnitudes, axis cases and operand ordering.
`default_nettype none
module qa_front import qa_pkg::*; #(
  parameter int W = DEFAULT_COMPONENT_WIDTH
) (
  input  logic [W-1:0] opp,
  input  logic [W-1:0] adj,
  output logic [W-1:0] num,
  output logic [W-1:0] den,
  output qa_flags_t    flags
);
  logic         yneg, xneg;
  logic [W-1:0] ay, ax;

  always_comb begin
    yneg = opp[W-1];
    xneg = adj[W-1];
    ay   = yneg ? (~opp + {{(W-1){1'b0}}, 1'b1}) : opp;
    ax   = xneg ? (~adj + {{(W-1){1'b0}}, 1'b1}) : adj;
    flags.yneg    = yneg;
    flags.xneg    = xneg;
    flags.ylt     = ay < ax;
    flags.eq      = ay == ax;
    flags.special = (ay == '0) || (ax == '0);
    if (ay == '0) begin
      flags.spec_angle = xneg ? ANGLE_W'(HALF_TURN) : '0;
    end else begin
      flags.spec_angle = yneg ? ANGLE_W'(THREE_QUARTER_TURN) : ANGLE_W'(QUARTER_TURN);
    end
    num = flags.ylt ? ay : ax;
    den = flags.ylt ? ax : ay;
  end
endmodule
`default_nettype wire

// ===== sv/qa_queue.sv =====
// Small first-in first-out queue between the front and back ends.
`default_nettype none
module qa_queue import qa_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              rd,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr, do_rd;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`include "quadrant_atan2_approximation_assert.svh"
  `QA_ASSERT_RST(a_q_reset_empty, rst |=> (count == '0))
  `QA_ASSERT(a_q_bound, count <= CNT_W'(DEPTH))
  `QA_ASSERT(a_q_grow, (do_wr && !do_rd) |=> (count == $past(count) + CNT_W'(1)))
endmodule
`default_nettype wire

// ===== sv/qa_back.sv =====
// Back end: pipelined ratio division, correction and quadrant folding.
`default_nettype none
module qa_back import qa_pkg::*; #(
  parameter int W = DEFAULT_COMPONENT_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [W-1:0]       in_num,
  input  logic [W-1:0]       in_den,
  input  qa_flags_t          in_flags,
  output logic               take,
  output logic               out_valid,
  output logic [ANGLE_W-1:0] out_angle,
  input  logic               pop
);
  localparam int NS = FRAC_STEPS;

  logic adv;
  assign adv  = !out_valid || pop;
  assign take = adv && in_valid;

  logic            vld    [1:NS];
  logic [W-1:0]    rem_q  [1:NS];
  logic [W-1:0]    den_q  [1:NS];
  logic [NS-1:0]   quo_q  [1:NS];
  qa_flags_t       flg_q  [1:NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic            v_i;
    logic [W-1:0]    rem_i, den_i;
    logic [NS-1:0]   quo_i;
    qa_flags_t       flg_i;
    logic [W:0]      sh;
    logic            ge;
    if (s == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = in_num;
      assign den_i = in_den;
      assign quo_i = '0;
      assign flg_i = in_flags;
    end else begin : g_next
      assign v_i   = vld[s];
      assign rem_i = rem_q[s];
      assign den_i = den_q[s];
      assign quo_i = quo_q[s];
      assign flg_i = flg_q[s];
    end
    assign sh = {rem_i, 1'b0};
    assign ge = sh >= {1'b0, den_i};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= v_i;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[s+1] <= ge ? W'(sh - {1'b0, den_i}) : W'(sh);
        den_q[s+1] <= den_i;
        quo_q[s+1] <= {quo_i[NS-2:0], ge};
        flg_q[s+1] <= flg_i;
      end
    end
  end

  // Rounded ratio and correction product.
  logic [RATIO_W:0]   qsum;
  logic [RATIO_W-1:0] r_c;
  logic               va, vb;
  logic [RATIO_W-1:0] ra, rb;
  logic [PROD_W-1:0]  pa;
  qa_flags_t          fa, fb;
  logic [SCALED_W-1:0]     u;
  logic [RECIP_PROD_W-1:0] tb;

  assign qsum = {1'b0, quo_q[NS]} + (RATIO_W + 1)'(1);
  assign r_c  = flg_q[NS].eq ? RATIO_W'(FULL_TURN) : RATIO_W'(qsum >> 1);
  assign u    = SCALED_W'(pa >> CORR_PRE_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (adv) begin
      va <= vld[NS];
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra <= r_c;
      pa <= PROD_W'(RATIO_W'(FULL_TURN) - r_c) * PROD_W'(r_c);
      fa <= flg_q[NS];
      rb <= ra;
      tb <= RECIP_PROD_W'(u) * RECIP_PROD_W'(RECIP);
      fb <= fa;
    end
  end

  // Final angle and quadrant fold.
  logic [RATIO_W-1:0]   corr, a_c;
  logic [ANGLE_W-2:0]   a3, q1;
  logic [ANGLE_W-1:0]   q, ang;

  always_comb begin
    corr = RATIO_W'(tb >> RECIP_SHIFT);
    a_c  = rb + corr;
    a3   = (ANGLE_W - 1)'(a_c >> 3);
    q1   = fb.ylt ? a3 : (ANGLE_W - 1)'(QUARTER_TURN) - a3;
    q    = {1'b0, q1};
    if (fb.special) begin
      ang = fb.spec_angle;
    end else if (q == '0) begin
      ang = fb.xneg ? ANGLE_W'(HALF_TURN) : '0;
    end else if (fb.yneg && fb.xneg) begin
      ang = q + ANGLE_W'(HALF_TURN);
    end else if (fb.yneg) begin
      ang = ANGLE_W'(FULL_TURN - 1) - q + ANGLE_W'(1);
    end else if (fb.xneg) begin
      ang = ANGLE_W'(HALF_TURN) - q;
    end else begin
      ang = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_angle <= ang;
    end
  end

`include "quadrant_atan2_approximation_assert.svh"
  `QA_ASSERT_RST(a_b_reset_idle, rst |=> !out_valid)
  `QA_ASSERT(a_b_hold_result, (out_valid && !pop) |=> out_valid)
  `QA_ASSERT(a_b_hold_stage, (vld[NS] && !adv) |=> vld[NS])
endmodule
`default_nettype wire

// ===== sv/quadrant_atan2_approximation.sv =====
// Top level of the quadrant arctangent block with a 14-bit angle.
//
//  channel  | handshake      | payload
//  ---------+----------------+------------------------------------------
//  input    | push / full    | opposite_component, adjacent_component
//  result   | pop / empty    | angle (16384 per full turn)
//
// One transaction enters per cycle while the queue is not full, and one
// result leaves per cycle when pop is kept high. The queue entry is written
// at the accepting edge; fifteen division stages (one quotient bit each),
// two correction stages and the output register then follow in order.
// A stalled output freezes the back pipeline; the front keeps taking
// transactions until the queue is full.
// Synchronous reset empties the queue and every pipeline stage.
`default_nettype none
module quadrant_atan2_approximation import qa_pkg::*; #(
  parameter int COMPONENT_WIDTH = DEFAULT_COMPONENT_WIDTH,
  parameter int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [COMPONENT_WIDTH-1:0] opposite_component,
  input  logic [COMPONENT_WIDTH-1:0] adjacent_component,
  output logic                       empty,
  input  logic                       pop,
  output logic [ANGLE_W-1:0]         angle
);
  localparam int ITEM_W = 2 * COMPONENT_WIDTH + FLAGS_W;

  // The front end orders the magnitudes so the ratio is at most one and
  // resolves the axis cases up front.
  logic [COMPONENT_WIDTH-1:0] f_num, f_den, b_num, b_den;
  qa_flags_t                  f_flags, b_flags;
  logic [ITEM_W-1:0]          q_rdata;
  logic                       q_empty, b_take, b_valid;

  qa_front #(.W(COMPONENT_WIDTH)) u_front (
    .opp   (opposite_component),
    .adj   (adjacent_component),
    .num   (f_num),
    .den   (f_den),
    .flags (f_flags)
  );

  // The queue lets the front accept transactions while the back stalls.
  qa_queue #(.DATA_W(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata ({f_num, f_den, f_flags}),
    .full  (full),
    .rd    (b_take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_num, b_den, b_flags} = q_rdata;

  // The back end divides, corrects and folds the angle into its quadrant.
  qa_back #(.W(COMPONENT_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_num    (b_num),
    .in_den    (b_den),
    .in_flags  (b_flags),
    .take      (b_take),
    .out_valid (b_valid),
    .out_angle (angle),
    .pop       (pop)
  );

  assign empty = !b_valid;
endmodule
`default_nettype wire

// ===== tb/tb_quadrant_atan2_approximation.sv =====
// Self-checking testbench of the quadrant arctangent block.
`default_nettype none
module tb_quadrant_atan2_approximation;
  import qa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = DEFAULT_COMPONENT_WIDTH;

  // Scoreboard: predicts the angle of each accepted transaction and compares
  // results in order against the pending predictions.
  class angle_scoreboard;
    logic [ANGLE_W-1:0] pending_angles[$];
    int                 failures = 0;

    // Rounded ratio num * 16384 / den, ties upward; num <= den.
    function automatic int ratio_of(logic [CW-1:0] num, logic [CW-1:0] den);
      logic [CW:0] rem;
      int          q;
      rem = {1'b0, num};
      q = 0;
      if (num >= den) return FULL_TURN;
      for (int i = 0; i < 15; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          q = q | 1;
        end
      end
      return (q + 1) >> 1;
    endfunction

    function automatic int corrected(int r);
      return r + ((FULL_TURN - r) * r) / 46080;
    endfunction

    function automatic int predict_angle(logic [CW-1:0] y, logic [CW-1:0] x);
      logic          yneg, xneg;
      logic [CW-1:0] ay, ax;
      int            q;
      yneg = y[CW-1];
      xneg = x[CW-1];
      // Negation in CW bits gives the exact magnitude, even of the most
      // negative value, when read as unsigned.
      ay = yneg ? -y : y;
      ax = xneg ? -x : x;
      if (ay == 0) return xneg ? HALF_TURN : 0;
      if (ax == 0) return yneg ? THREE_QUARTER_TURN : QUARTER_TURN;
      if (ay < ax) q = corrected(ratio_of(ay, ax)) >> 3;
      else q = QUARTER_TURN - (corrected(ratio_of(ax, ay)) >> 3);
      if (q == 0) return xneg ? HALF_TURN : 0;
      if (yneg) return xneg ? q + HALF_TURN : FULL_TURN - q;
      return xneg ? HALF_TURN - q : q;
    endfunction

    function void note_input(logic [CW-1:0] y, logic [CW-1:0] x);
      pending_angles.push_back(ANGLE_W'(predict_angle(y, x)));
    endfunction

    function void check_result(logic [ANGLE_W-1:0] got);
      logic [ANGLE_W-1:0] want;
      if (pending_angles.size() == 0) begin
        $error("unexpected result transaction: angle %0d", got);
        failures++;
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        $error("angle mismatch: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic [CW-1:0]      opposite_component = '0;
  logic [CW-1:0]      adjacent_component = '0;
  logic               full, empty;
  logic [ANGLE_W-1:0] angle;

  angle_scoreboard board = new();

  // Idle percentages per phase; the control process updates them.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  phase = -1;
  bit  hold_off = 1'b0;

  quadrant_atan2_approximation dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .opposite_component(opposite_component),
    .adjacent_component(adjacent_component),
    .empty(empty), .pop(pop), .angle(angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one transaction, idling at random first, and holds push until the
  // block accepts it. Push stays high into the next transaction when there is
  // no idle, so it is never lowered and raised in the same step.
  task automatic send_vector(logic [CW-1:0] y, logic [CW-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opposite_component <= y;
    adjacent_component <= x;
    do @(posedge clk); while (full);
    board.note_input(y, x);
  endtask

  function automatic logic [CW-1:0] random_component();
    logic [CW-1:0] v;
    v = CW'({$urandom, $urandom});
    case ($urandom_range(7))
      0: v = '0;
      1: v = {1'b1, {(CW-1){1'b0}}};
      2: v = {1'b0, {(CW-1){1'b1}}};
      3: v = v >>> $urandom_range(CW - 1);  // logical shift, so the result is non-negative unless the shift is zero
      4: v = $signed(v) >>> $urandom_range(CW - 1);
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: pops at random; the hold-off blocks popping entirely.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) board.check_result(angle);
      pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long hold-off of the receiver, counted in its own process, so that the
  // block fills up and drops full onto the sender.
  initial begin
    wait (phase == 2);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE = 1;

  initial begin
    logic [CW-1:0] m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the zero vector, both axes, equal magnitudes in every
    // quadrant, extremes of the fields, and tiny ratios that fold to zero.
    send_vector('0, '0);
    send_vector('0, ONE);
    send_vector('0, -ONE);
    send_vector(ONE, '0);
    send_vector(-ONE, '0);
    send_vector(MINN, '0);
    send_vector('0, MINN);
    send_vector(5, 5);
    send_vector(-5, 5);
    send_vector(5, -5);
    send_vector(-5, -5);
    send_vector(MINN, MINN);
    send_vector(MAXP, MINN);
    send_vector(MINN, MAXP);
    send_vector(MAXP, MAXP);
    send_vector(ONE, MAXP);
    send_vector(-ONE, MAXP);
    send_vector(ONE, MINN);
    send_vector(-ONE, MINN);
    send_vector(MAXP, ONE);
    send_vector(MINN, -ONE);
    send_vector(3, 7);
    send_vector(-7, 3);
    send_vector({CW{1'b1}}, {CW{1'b1}});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      phase = ph;
      for (int i = 0; i < 150; i++) begin
        m = random_component();
        send_vector(m, $urandom_range(3) == 0 ? m : random_component());
      end
    end
    push <= 1'b0;
    recv_stall_pct = 0;

    while (board.pending_angles.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/qa_pkg.sv
sv/qa_front.sv
sv/qa_queue.sv
sv/qa_back.sv
sv/quadrant_atan2_approximation.sv
tb/tb_quadrant_atan2_approximation.sv
